// ===== src/dle_pkg.sv =====
// Shared types and constants for the DLE/ETX packet deframer.
`timescale 1ns / 1ps

package dle_pkg;

   // Framing characters
   localparam logic [7:0] CH_DLE = 8'h10;
   localparam logic [7:0] CH_ETX = 8'h03;

   // Packet ids and subcodes that the classifier knows
   localparam logic [7:0] ID_TIMING   = 8'h8f;
   localparam logic [7:0] ID_VERSION  = 8'h45;
   localparam logic [7:0] SUB_PRIMARY = 8'hab;
   localparam logic [7:0] SUB_SUPPL   = 8'hac;
   localparam logic [7:0] SUB_MASK    = 8'ha5;

   // Required payload lengths
   localparam int LEN_PRIMARY = 17;
   localparam int LEN_VERSION = 10;
   localparam int LEN_SUPPL   = 68;

   // Result field widths
   localparam int KIND_W  = 3;
   localparam int CLASS_W = 3;
   localparam int IDX_W   = 10;
   localparam int LEN_W   = 11;

   // Depth of the token queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // Escape-decoded token from the front
   typedef enum logic [1:0] {
      TOK_DATA,
      TOK_START,
      TOK_END
   } tok_kind_type;

   typedef struct packed {
      tok_kind_type kind;
      logic [7:0]   value;
   } token_type;

   // Result kinds
   typedef enum logic [KIND_W-1:0] {
      KIND_PAYLOAD  = 3'd0,
      KIND_END      = 3'd1,
      KIND_ABORT    = 3'd2,
      KIND_NO_START = 3'd3,
      KIND_OVERFLOW = 3'd4
   } kind_type;

   // Packet classes
   typedef enum logic [CLASS_W-1:0] {
      CLASS_PRIMARY = 3'd0,
      CLASS_VERSION = 3'd1,
      CLASS_SUPPL   = 3'd2,
      CLASS_MASK    = 3'd3,
      CLASS_UNKNOWN = 3'd4
   } class_type;

   // Back-end framing state
   typedef enum logic {
      MODE_HUNT,
      MODE_DATA
   } mode_type;

   // One result item
   typedef struct packed {
      kind_type         kind;
      logic [7:0]       packet_id;
      logic [7:0]       data_byte;
      logic [IDX_W-1:0] byte_index;
      class_type        packet_class;
      logic [LEN_W-1:0] payload_length;
      logic             length_ok;
      logic             is_last;
   } result_type;

endpackage

// ===== src/dle_front.sv =====
// Front end: accepts bytes and resolves DLE escapes into tokens.
`timescale 1ns / 1ps

module dle_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [7:0]          req_rx_byte,
   output logic                req_stall,
   input  logic                q_full,
   output logic                push,
   output dle_pkg::token_type  push_tok
);
   import dle_pkg::*;

   logic take;
   logic dle_pending_ff;
   logic dle_pending_in;

   assign req_stall = q_full;
   assign take      = req_valid && !q_full;

   // Escape decode: DLE DLE is a data DLE, DLE ETX ends, DLE x starts with id x
   always_comb begin
      dle_pending_in = dle_pending_ff;
      push           = 1'b0;
      push_tok.kind  = TOK_DATA;
      push_tok.value = req_rx_byte;
      if (take) begin
         if (!dle_pending_ff) begin
            if (req_rx_byte == CH_DLE) begin
               dle_pending_in = 1'b1;
            end else begin
               push = 1'b1;
            end
         end else begin
            dle_pending_in = 1'b0;
            push           = 1'b1;
            if (req_rx_byte == CH_DLE) begin
               push_tok.kind = TOK_DATA;
            end else if (req_rx_byte == CH_ETX) begin
               push_tok.kind = TOK_END;
            end else begin
               push_tok.kind = TOK_START;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dle_pending_ff <= 1'b0;
      end else begin
         dle_pending_ff <= dle_pending_in;
      end
   end

endmodule

// ===== src/dle_queue.sv =====
// Short token queue that decouples the front end from the back end.
`timescale 1ns / 1ps

module dle_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  dle_pkg::token_type  push_tok,
   input  logic                pop,
   output logic                full,
   output logic                not_empty,
   output dle_pkg::token_type  head_tok
);
   import dle_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   token_type        slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             do_push;
   logic             do_pop;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_tok  = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   // Pointer and fill-count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_tok;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue fill count beyond depth");

endmodule

// ===== src/dle_back.sv =====
// Back end: packet framing state, payload indexing, classification, result register.
`timescale 1ns / 1ps

module dle_back #(
   parameter int MAX_PAYLOAD = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 tok_valid,
   input  dle_pkg::token_type   tok,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output dle_pkg::result_type  rsp
);
   import dle_pkg::*;

   localparam int CNT_W  = $clog2(MAX_PAYLOAD + 1);
   localparam int WIDE_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

   mode_type         mode_ff;
   mode_type         mode_in;
   logic [7:0]       id_ff;
   logic [7:0]       id_in;
   logic [7:0]       sub_ff;
   logic [7:0]       sub_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [WIDE_W-1:0] count_wide;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   result_type       rsp_ff;
   result_type       rsp_in;
   logic             overflow;
   logic             has_bytes;
   class_type        cls;
   logic             len_ok;

   assign pop        = tok_valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp        = rsp_ff;
   assign overflow   = (count_ff >= CNT_W'(MAX_PAYLOAD));
   assign has_bytes  = (count_ff != '0);
   assign count_wide = WIDE_W'(count_ff);

   // Packet classification from id, subcode and length
   always_comb begin
      if (id_ff == ID_TIMING && has_bytes && sub_ff == SUB_PRIMARY) begin
         cls    = CLASS_PRIMARY;
         len_ok = (count_wide == WIDE_W'(LEN_PRIMARY));
      end else if (id_ff == ID_VERSION) begin
         cls    = CLASS_VERSION;
         len_ok = (count_wide == WIDE_W'(LEN_VERSION));
      end else if (id_ff == ID_TIMING && has_bytes && sub_ff == SUB_SUPPL) begin
         cls    = CLASS_SUPPL;
         len_ok = (count_wide == WIDE_W'(LEN_SUPPL));
      end else if (id_ff == ID_TIMING && has_bytes && sub_ff == SUB_MASK) begin
         cls    = CLASS_MASK;
         len_ok = 1'b1;
      end else begin
         cls    = CLASS_UNKNOWN;
         len_ok = 1'b0;
      end
   end

   // Next framing state
   always_comb begin
      mode_in = mode_ff;
      if (pop) begin
         case (mode_ff)
            MODE_HUNT: begin
               if (tok.kind == TOK_START) begin
                  mode_in = MODE_DATA;
               end
            end
            MODE_DATA: begin
               case (tok.kind)
                  TOK_DATA:  mode_in = overflow ? MODE_HUNT : MODE_DATA;
                  TOK_END:   mode_in = MODE_HUNT;
                  TOK_START: mode_in = MODE_DATA;
                  default:   mode_in = MODE_HUNT;
               endcase
            end
            default: mode_in = MODE_HUNT;
         endcase
      end
   end

   // Packet registers and result item
   always_comb begin
      id_in        = id_ff;
      sub_in       = sub_ff;
      count_in     = count_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (pop) begin
         rsp_in.kind           = KIND_PAYLOAD;
         rsp_in.packet_id      = id_ff;
         rsp_in.data_byte      = '0;
         rsp_in.byte_index     = '0;
         rsp_in.packet_class   = CLASS_PRIMARY;
         rsp_in.payload_length = '0;
         rsp_in.length_ok      = 1'b0;
         rsp_in.is_last        = 1'b0;
         case (mode_ff)
            MODE_HUNT: begin
               if (tok.kind == TOK_START) begin
                  id_in    = tok.value;
                  sub_in   = '0;
                  count_in = '0;
               end else if (tok.kind == TOK_END) begin
                  rsp_valid_in     = 1'b1;
                  rsp_in.kind      = KIND_NO_START;
                  rsp_in.packet_id = '0;
               end
            end
            MODE_DATA: begin
               rsp_valid_in = 1'b1;
               case (tok.kind)
                  TOK_DATA: begin
                     if (overflow) begin
                        rsp_in.kind           = KIND_OVERFLOW;
                        rsp_in.payload_length = count_wide[LEN_W-1:0];
                        rsp_in.is_last        = 1'b1;
                     end else begin
                        rsp_in.data_byte  = tok.value;
                        rsp_in.byte_index = count_wide[IDX_W-1:0];
                        if (!has_bytes) begin
                           sub_in = tok.value;
                        end
                        count_in = count_ff + 1'b1;
                     end
                  end
                  TOK_END: begin
                     rsp_in.kind           = KIND_END;
                     rsp_in.packet_class   = cls;
                     rsp_in.payload_length = count_wide[LEN_W-1:0];
                     rsp_in.length_ok      = len_ok;
                     rsp_in.is_last        = 1'b1;
                  end
                  default: begin
                     // lone DLE: abort the old packet, open a new one
                     rsp_in.kind           = KIND_ABORT;
                     rsp_in.payload_length = count_wide[LEN_W-1:0];
                     rsp_in.is_last        = 1'b1;
                     id_in                 = tok.value;
                     sub_in                = '0;
                     count_in              = '0;
                  end
               endcase
            end
            default: begin
               rsp_valid_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_HUNT;
         id_ff        <= '0;
         sub_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         id_ff        <= id_in;
         sub_ff       <= sub_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_PAYLOAD))
      else $error("payload count beyond maximum");

   a_no_pop_stalled: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !pop)
      else $error("token consumed while result held");

   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.is_last ==
         (rsp_ff.kind == KIND_END || rsp_ff.kind == KIND_ABORT ||
          rsp_ff.kind == KIND_OVERFLOW)))
      else $error("is_last does not match result kind");

   a_hunt_after_close: assert property (@(posedge clock) disable iff (reset)
      (pop && mode_ff == MODE_DATA && tok.kind == TOK_END) |=> (mode_ff == MODE_HUNT))
      else $error("framing did not return to hunt after packet end");

endmodule

// ===== src/dle_etx_packet_deframer_unit.sv =====
// Top level of the DLE/ETX packet deframer.
`timescale 1ns / 1ps

// Takes one serial byte per item and recovers packets framed as DLE id payload
// DLE ETX with DLE DLE stuffing. Each payload byte comes out as a result item
// with its packet id and index; DLE ETX gives a packet-end item with class,
// length and length check; a lone DLE aborts and restarts, DLE ETX outside a
// packet and payload overflow are flagged. A byte enters every cycle while the
// queue is not full: the front end resolves escapes with a single pending-DLE
// flag, a four-token queue feeds the back end, and the back end turns one token
// per cycle, unless rsp_stall holds its result, into at most one result in its
// output register. No clearing pass after reset is needed.

module dle_etx_packet_deframer_unit #(
   parameter int MAX_PAYLOAD = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [7:0]  rsp_packet_id,
   output logic [7:0]  rsp_data_byte,
   output logic [9:0]  rsp_byte_index,
   output logic [2:0]  rsp_packet_class,
   output logic [10:0] rsp_payload_length,
   output logic        rsp_length_ok,
   output logic        rsp_is_last
);
   import dle_pkg::*;

   logic       push;
   token_type  push_tok;
   logic       q_full;
   logic       q_not_empty;
   token_type  head_tok;
   logic       pop;
   result_type rsp;

   dle_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_rx_byte (req_rx_byte),
      .req_stall   (req_stall),
      .q_full      (q_full),
      .push        (push),
      .push_tok    (push_tok)
   );

   dle_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_tok  (push_tok),
      .pop       (pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head_tok  (head_tok)
   );

   dle_back #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .tok_valid (q_not_empty),
      .tok       (head_tok),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   // Result fields onto their ports
   assign rsp_kind           = rsp.kind;
   assign rsp_packet_id      = rsp.packet_id;
   assign rsp_data_byte      = rsp.data_byte;
   assign rsp_byte_index     = rsp.byte_index;
   assign rsp_packet_class   = rsp.packet_class;
   assign rsp_payload_length = rsp.payload_length;
   assign rsp_length_ok      = rsp.length_ok;
   assign rsp_is_last        = rsp.is_last;

endmodule
